### rtl/core/hsa_pkg.sv
// shared action and status codes of the handle slot allocator
`timescale 1ns / 1ps

package hsa_pkg;

  // action codes of an input transfer
  localparam logic [1:0] ACT_PUT    = 2'd0;
  localparam logic [1:0] ACT_PUT_AT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_GET    = 2'd3;

  // status codes of a result transfer
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_FULL       = 2'd1;
  localparam logic [1:0] STAT_BAD_HANDLE = 2'd2;
  localparam logic [1:0] STAT_ZERO_PUT   = 2'd3;

endpackage

### rtl/core/handle_slot_allocator_core.sv
// handle table with next-fit free slot search, top level
`timescale 1ns / 1ps

// Fixed-capacity handle table. A slot is occupied when its word is nonzero.
// Input channel (in_valid/in_ready): one action with a handle and a payload.
//   put searches for a free slot from the next-search pointer, wrapping;
//   put-to-slot writes a slot; remove clears one; get reads one.
// Result channel (out_valid/out_ready): one transfer per action, carrying a
//   status, the handle given by a put, the word read, removed or replaced,
//   and the occupancy count after the action.
// One action is in flight at a time; in_ready is low until its result has
//   been taken by the receiver.
// Steps from input transfer to out_valid: error cases go straight to the result;
//   get, remove and put-to-slot make one memory read, then the write; put
//   probes slots until it finds a free one, one per cycle through the
//   single read port of the table memory. With a ready receiver, in_ready
//   rises again in the cycle after the result transfer.
// Reset: a clearing pass writes zero into every slot, one slot a cycle, so
//   in_ready stays low after rst_n is released until the pass is done.
// Receiver stall: the result stays in the output registers, stable, and no
//   new action is taken until the result transfer happens.
module handle_slot_allocator_core
  import hsa_pkg::*;
#(
  parameter int CAPACITY  = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [11:0] in_handle,
  input  logic [31:0] in_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [10:0] out_handle_out,
  output logic [31:0] out_word_out,
  output logic [10:0] out_occupied_count
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_ACCESS,
    S_RESP
  } state_t;

  // slot memory, one write and one registered read per cycle
  logic [WORD_BITS-1:0] mem [CAPACITY];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [IDX_W-1:0]     rd_addr;

  // control state
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;

  // captured action and working pointer
  logic [1:0]           act_r, act_nxt;
  logic [IDX_W-1:0]     ptr_r, ptr_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;

  // result registers
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [10:0] hout_r, hout_nxt;
  logic [31:0] wout_r, wout_nxt;

  logic             handle_ok;
  logic [IDX_W-1:0] in_idx;
  logic [IDX_W-1:0] ptr_inc;
  logic             rd_zero;

  assign handle_ok = (in_handle != 12'd0) && ({1'b0, in_handle} <= 13'(CAPACITY));
  assign in_idx    = IDX_W'(in_handle - 12'd1);
  // wrapping step of the probe pointer, shared by the probe and the next-search pointer
  assign ptr_inc   = (ptr_r == IDX_W'(CAPACITY - 1)) ? '0 : ptr_r + IDX_W'(1);
  assign rd_zero   = (rd_data_r == '0);

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    count_nxt     = count_r;
    start_nxt     = start_r;
    act_nxt       = act_r;
    ptr_nxt       = ptr_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    hout_nxt      = hout_r;
    wout_nxt      = wout_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r;
    wr_data       = word_r;
    rd_addr       = ptr_r;

    case (state_r)
      S_CLEAR: begin
        // sweep zero through every slot after reset
        wr_en       = 1'b1;
        wr_addr     = clr_idx_r;
        wr_data     = '0;
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == IDX_W'(CAPACITY - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          act_nxt    = in_action;
          word_nxt   = WORD_BITS'(in_payload);
          status_nxt = STAT_OK;
          hout_nxt   = '0;
          wout_nxt   = '0;
          if (in_action == ACT_PUT) begin
            if (WORD_BITS'(in_payload) == '0) begin
              status_nxt    = STAT_ZERO_PUT;
              out_valid_nxt = 1'b1;
              state_nxt     = S_RESP;
            end else if (count_r >= CNT_W'(CAPACITY)) begin
              status_nxt    = STAT_FULL;
              out_valid_nxt = 1'b1;
              state_nxt     = S_RESP;
            end else begin
              // first probe at the next-search pointer
              ptr_nxt   = start_r;
              rd_addr   = start_r;
              state_nxt = S_SEARCH;
            end
          end else if (!handle_ok) begin
            status_nxt    = STAT_BAD_HANDLE;
            out_valid_nxt = 1'b1;
            state_nxt     = S_RESP;
          end else if ((in_action == ACT_PUT_AT) && (WORD_BITS'(in_payload) == '0)) begin
            status_nxt    = STAT_ZERO_PUT;
            out_valid_nxt = 1'b1;
            state_nxt     = S_RESP;
          end else begin
            ptr_nxt   = in_idx;
            rd_addr   = in_idx;
            state_nxt = S_ACCESS;
          end
        end
      end
      S_SEARCH: begin
        // rd_data_r holds the word of slot ptr_r
        if (rd_zero) begin
          wr_en         = 1'b1;
          wr_addr       = ptr_r;
          wr_data       = word_r;
          count_nxt     = count_r + CNT_W'(1);
          start_nxt     = ptr_inc;
          hout_nxt      = 11'({1'b0, ptr_r} + {{IDX_W{1'b0}}, 1'b1});
          out_valid_nxt = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          // occupancy count below capacity guarantees a free slot ahead
          ptr_nxt = ptr_inc;
          rd_addr = ptr_inc;
        end
      end
      S_ACCESS: begin
        wout_nxt = 32'(rd_data_r);
        case (act_r)
          ACT_PUT_AT: begin
            wr_en   = 1'b1;
            wr_data = word_r;
            if (rd_zero) begin
              count_nxt = count_r + CNT_W'(1);
            end
          end
          ACT_REMOVE: begin
            wr_en     = 1'b1;
            wr_data   = '0;
            start_nxt = ptr_r;
            if (!rd_zero && (count_r != '0)) begin
              count_nxt = count_r - CNT_W'(1);
            end
          end
          default: begin
            // get only reads
          end
        endcase
        out_valid_nxt = 1'b1;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      count_r     <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      count_r     <= count_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r    <= act_nxt;
    ptr_r    <= ptr_nxt;
    word_r   <= word_nxt;
    status_r <= status_nxt;
    hout_r   <= hout_nxt;
    wout_r   <= wout_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_handle_out     = hout_r;
  assign out_word_out       = wout_r;
  assign out_occupied_count = 11'(count_r);

endmodule

### rtl/core/hsa_checker.sv
// port-level checker of the handle slot allocator and its bind
`timescale 1ns / 1ps

module hsa_checker
  import hsa_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [10:0] out_handle_out,
  input logic [31:0] out_word_out,
  input logic [10:0] out_occupied_count
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_handle_out) && $stable(out_word_out)
      && $stable(out_occupied_count))
    else $error("stalled result changed");

  // one action in flight: no intake while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while result pending");

  // a transfer in makes in_ready low in the next cycle
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready again before result");

  // errors give no handle and no word
  a_error_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_handle_out == 11'd0
      && out_word_out == 32'd0)
    else $error("error result carries data");

endmodule

bind handle_slot_allocator_core hsa_checker u_hsa_checker (.*);
